/* sv/rcl_pkg.sv */
// rcl_pkg: shared types and constants for the crop and luma conversion block
// no dependencies; imported by rgb_crop_to_luma_core, rcl_scan and rcl_calc
`default_nettype none

package rcl_pkg;

    // position and size limits of the source raster
    localparam int unsigned MAX_PITCH = 16384;
    localparam int unsigned BIR_W     = 14;
    localparam int unsigned ROW_W     = 13;
    localparam int unsigned COL_W     = 14;
    localparam logic [ROW_W-1:0] ROW_SAT = 13'h1FFF;

    // register indexes of the configuration port
    localparam logic [2:0] REG_CROP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CROP_TOP    = 3'd1;
    localparam logic [2:0] REG_CROP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CROP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ROW_PITCH   = 3'd4;
    localparam logic [2:0] REG_BPP         = 3'd5;
    localparam logic [2:0] REG_CHANNEL_MAP = 3'd6;

    // bt601 luma weights in 10-bit fixed point
    localparam logic [17:0] COEF_R    = 18'd306;
    localparam logic [17:0] COEF_G    = 18'd601;
    localparam logic [17:0] COEF_B    = 18'd117;
    localparam logic [17:0] ROUND_ADD = 18'h200;
    localparam int unsigned LUMA_SHIFT = 10;

    // reciprocal of three in 16-bit fraction, exact for 14-bit dividends
    localparam logic [15:0] RECIP3 = 16'd21846;

    typedef struct packed {
        logic [11:0] crop_left;
        logic [11:0] crop_top;
        logic [12:0] crop_width;
        logic [12:0] crop_height;
        logic [14:0] row_pitch;
        logic [2:0]  bytes_per_pixel;
        logic [5:0]  channel_map;
    } cfg_t;

    // first pipeline stage: position and captured channel bytes
    typedef struct packed {
        logic [7:0]       byte_val;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [BIR_W-1:0] bir;
        logic [ROW_W-1:0] row;
        logic             last;
        logic [2:0]       bpp;
    } s1_t;

    // second pipeline stage: pixel column, luma and row window result
    typedef struct packed {
        logic [7:0]       luma;
        logic [COL_W-1:0] col;
        logic             row_ok;
        logic             row_last;
    } s2_t;

endpackage

`default_nettype wire

/* sv/rgb_crop_to_luma_core.sv */
// rgb_crop_to_luma_core: crop window and bt601 gray conversion of a byte stream
// an accepted word passes the first stage, second stage and output registers to its luma word
// throughput: one source byte per cycle while the output is not stalled, through the three-stage register pipeline
// a word is taken while a finished result waits, as long as a stage is free
// reset: asynchronous, active low; clears position, stage valids and settings
// depends on rcl_pkg, rcl_scan and rcl_calc
`default_nettype none

module rgb_crop_to_luma_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  src_byte,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       luma,
    output logic             row_end,
    output logic             frame_end
);
    import rcl_pkg::*;

    cfg_t             cfg_reg;
    s1_t              s1;
    s2_t              s2;
    logic             s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic             out_free, s2_adv, s2_take, s1_adv, accept;
    logic [COL_W-1:0] col_diff;
    logic             col_ok, win, row_last;
    logic [7:0]       luma_reg;
    logic             row_end_reg, frame_end_reg;

    // settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crop_left       <= 12'd0;
            cfg_reg.crop_top        <= 12'd0;
            cfg_reg.crop_width      <= 13'd1;
            cfg_reg.crop_height     <= 13'd1;
            cfg_reg.row_pitch       <= 15'd1;
            cfg_reg.bytes_per_pixel <= 3'd1;
            cfg_reg.channel_map     <= 6'd36;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CROP_LEFT:   cfg_reg.crop_left       <= cfg_data[11:0];
                REG_CROP_TOP:    cfg_reg.crop_top        <= cfg_data[11:0];
                REG_CROP_WIDTH:  cfg_reg.crop_width      <= cfg_data[12:0];
                REG_CROP_HEIGHT: cfg_reg.crop_height     <= cfg_data[12:0];
                REG_ROW_PITCH:   cfg_reg.row_pitch       <= cfg_data;
                REG_BPP:         cfg_reg.bytes_per_pixel <= cfg_data[2:0];
                REG_CHANNEL_MAP: cfg_reg.channel_map     <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    // pipeline flow control: a stage moves on when the next one is free or moving
    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        s2_adv   = s2_valid_reg && out_free;
        s2_take  = !s2_valid_reg || s2_adv;
        s1_adv   = s1_valid_reg && s2_take;
        in_ready = !s1_valid_reg || s1_adv;
        accept   = in_valid && in_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_take)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    rcl_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .src_byte    (src_byte),
        .frame_start (frame_start),
        .cfg         (cfg_reg),
        .s1          (s1)
    );

    rcl_calc u_calc (
        .clk  (clk),
        .load (s1_adv),
        .s1   (s1),
        .cfg  (cfg_reg),
        .s2   (s2)
    );

    // column window test and end flags
    always_comb
    begin
        col_diff = s2.col - {2'b0, cfg_reg.crop_left};
        col_ok   = (s2.col >= {2'b0, cfg_reg.crop_left})
                   && ({1'b0, col_diff} < {2'b0, cfg_reg.crop_width});
        win      = s2.row_ok && col_ok;
        row_last = ((15'(col_diff) + 15'd1) == {2'b0, cfg_reg.crop_width});
    end

    // output register; words outside the window are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_valid_reg && win;
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && win)
        begin
            luma_reg      <= s2.luma;
            row_end_reg   <= row_last;
            frame_end_reg <= row_last && s2.row_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign luma      = luma_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

/* sv/rcl_scan.sv */
// rcl_scan: byte, pixel and row position tracking and channel capture
// depends on rcl_pkg; loads the first pipeline stage on each accepted word
`default_nettype none

module rcl_scan (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    src_byte,
    input  wire logic          frame_start,
    input  wire rcl_pkg::cfg_t cfg,
    output rcl_pkg::s1_t       s1
);
    import rcl_pkg::*;

    logic [BIR_W-1:0] byte_in_row_reg, byte_in_row_next;
    logic [ROW_W-1:0] row_index_reg, row_index_next;
    logic [1:0]       byte_in_pixel_reg, byte_in_pixel_next;
    logic [7:0]       red_hold_reg, red_hold_next;
    logic [7:0]       green_hold_reg, green_hold_next;
    logic [7:0]       blue_hold_reg, blue_hold_next;
    s1_t              s1_reg, s1_next;

    logic [14:0]      pitch_eff;
    logic [2:0]       bpp_eff;
    logic [BIR_W-1:0] bir0, bir;
    logic [ROW_W-1:0] row0;
    logic [1:0]       bip0, bip;
    logic             last, wrap;

    // clamp pitch and pixel size to their usable ranges
    always_comb
    begin
        if (cfg.row_pitch == 15'd0)
            pitch_eff = 15'd1;
        else if (cfg.row_pitch > 15'(MAX_PITCH))
            pitch_eff = 15'(MAX_PITCH);
        else
            pitch_eff = cfg.row_pitch;

        if (cfg.bytes_per_pixel == 3'd0)
            bpp_eff = 3'd1;
        else if (cfg.bytes_per_pixel > 3'd4)
            bpp_eff = 3'd4;
        else
            bpp_eff = cfg.bytes_per_pixel;
    end

    // current position, with frame restart and wrap against the settings
    always_comb
    begin
        bir0 = frame_start ? '0 : byte_in_row_reg;
        row0 = frame_start ? '0 : row_index_reg;
        bip0 = frame_start ? '0 : byte_in_pixel_reg;
        bir  = ({1'b0, bir0} >= pitch_eff) ? '0 : bir0;
        bip  = ({1'b0, bip0} >= bpp_eff) ? '0 : bip0;
        last = (({1'b0, bip} + 3'd1) == bpp_eff);
        wrap = (({1'b0, bir} + 15'd1) >= pitch_eff);
    end

    // position advance and channel capture
    always_comb
    begin
        if (wrap)
        begin
            byte_in_row_next   = '0;
            byte_in_pixel_next = '0;
            row_index_next     = (row0 != ROW_SAT) ? row0 + 13'd1 : row0;
        end
        else
        begin
            byte_in_row_next   = bir + 14'd1;
            byte_in_pixel_next = last ? 2'd0 : bip + 2'd1;
            row_index_next     = row0;
        end
        red_hold_next   = (cfg.channel_map[1:0] == bip) ? src_byte : red_hold_reg;
        green_hold_next = (cfg.channel_map[3:2] == bip) ? src_byte : green_hold_reg;
        blue_hold_next  = (cfg.channel_map[5:4] == bip) ? src_byte : blue_hold_reg;

        s1_next.byte_val = src_byte;
        s1_next.red      = red_hold_next;
        s1_next.green    = green_hold_next;
        s1_next.blue     = blue_hold_next;
        s1_next.bir      = bir;
        s1_next.row      = row0;
        s1_next.last     = last;
        s1_next.bpp      = bpp_eff;
    end

    // position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg   <= '0;
            row_index_reg     <= '0;
            byte_in_pixel_reg <= '0;
            red_hold_reg      <= '0;
            green_hold_reg    <= '0;
            blue_hold_reg     <= '0;
        end
        else if (accept)
        begin
            byte_in_row_reg   <= byte_in_row_next;
            row_index_reg     <= row_index_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            red_hold_reg      <= red_hold_next;
            green_hold_reg    <= green_hold_next;
            blue_hold_reg     <= blue_hold_next;
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

/* sv/rcl_calc.sv */
// rcl_calc: pixel column, weighted luma sum and row window test
// depends on rcl_pkg; loads the second pipeline stage from the first
`default_nettype none

module rcl_calc (
    input  wire logic          clk,
    input  wire logic          load,
    input  wire rcl_pkg::s1_t  s1,
    input  wire rcl_pkg::cfg_t cfg,
    output rcl_pkg::s2_t       s2
);
    import rcl_pkg::*;

    s2_t              s2_reg, s2_next;
    logic [29:0]      prod3;
    logic [COL_W-1:0] col;
    logic [7:0]       r, g, b;
    logic [17:0]      sum;
    logic [ROW_W-1:0] row_diff;

    // pixel column: shifts for one, two and four bytes, reciprocal for three
    always_comb
    begin
        prod3 = 30'(s1.bir) * 30'(RECIP3);
        case (s1.bpp)
            3'd1:    col = s1.bir;
            3'd2:    col = s1.bir >> 1;
            3'd3:    col = prod3[29:16];
            default: col = s1.bir >> 2;
        endcase
    end

    // weighted sum; a channel beyond the pixel reads as zero
    always_comb
    begin
        r   = ({1'b0, cfg.channel_map[1:0]} < s1.bpp) ? s1.red   : 8'd0;
        g   = ({1'b0, cfg.channel_map[3:2]} < s1.bpp) ? s1.green : 8'd0;
        b   = ({1'b0, cfg.channel_map[5:4]} < s1.bpp) ? s1.blue  : 8'd0;
        sum = 18'(r) * COEF_R + 18'(g) * COEF_G + 18'(b) * COEF_B + ROUND_ADD;
    end

    // row window test and second stage payload
    always_comb
    begin
        row_diff = s1.row - {1'b0, cfg.crop_top};
        s2_next.luma     = (s1.bpp == 3'd1) ? s1.byte_val : sum[LUMA_SHIFT +: 8];
        s2_next.col      = col;
        s2_next.row_ok   = s1.last && (s1.row != ROW_SAT)
                           && (s1.row >= {1'b0, cfg.crop_top})
                           && (row_diff < cfg.crop_height);
        s2_next.row_last = ((14'(row_diff) + 14'd1) == {1'b0, cfg.crop_height});
    end

    always_ff @(posedge clk)
    begin
        if (load)
            s2_reg <= s2_next;
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

/* sv/rcl_checker.sv */
// rcl_checker: port-level checks of the crop and luma block
// depends on rgb_crop_to_luma_core; attached to it by the bind below
`default_nettype none

module rcl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] luma,
    input wire logic       row_end,
    input wire logic       frame_end
);

    // a stalled result word holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(luma)
                                    && $stable(row_end) && $stable(frame_end))
        else $error("result word changed while stalled");

    // with the output free, the pipeline always drains and takes a new word
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input blocked with the output free");

    // the last pixel of the window is also the last of its row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame end without row end");

    // a first result must follow an accepted source word or a release from reset
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && !$past(out_valid) && !$past(out_valid, 2)
            |-> $past(in_valid && in_ready, 2) || $past(in_valid && in_ready, 3)
                || $past(in_valid && in_ready, 4) || !$past(rst_n, 3))
        else $error("result word without a source word");

endmodule

bind rgb_crop_to_luma_core rcl_checker u_rcl_checker (.*);

`default_nettype wire
